// ===== rtl/hsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfd_pkg
// Types, constants and the CRC-8 step shared by the sensor frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    localparam logic [7:0]  CRC_INIT = 8'hFF;
    localparam logic [7:0]  CRC_POLY = 8'h31;
    localparam logic [10:0] T_SCALE  = 11'd1750;
    localparam logic [11:0] T_OFFSET = 12'd450;
    localparam logic [6:0]  H_SCALE  = 7'd100;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        POS_T_MSB = 3'd0,
        POS_T_LSB = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_MSB = 3'd3,
        POS_H_LSB = 3'd4,
        POS_H_CRC = 3'd5
    } t_pos;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic signed [11:0] temp_tenths;
        logic [6:0]         rh_pct;
        logic               status;
    } t_out;

    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
        logic        ok;
    } t_job;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/hsfd_front.sv =====
// ----------------------------------------------------------------------------
// hsfd_front
// Frame parser: tracks byte position, runs the CRC-8 over each word, and
// issues one job per completed frame.
// ----------------------------------------------------------------------------
module hsfd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  hsfd_pkg::t_in  i_data,
    output logic           o_job_push,
    output hsfd_pkg::t_job o_job
);
    import hsfd_pkg::*;

    t_pos        r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_humid, n_humid;
    logic        r_tgood, n_tgood;
    t_pos        pos;
    logic [7:0]  crc_next;

    always_comb begin
        if (i_data.frame_start || r_pos > POS_H_CRC) begin
            pos = POS_T_MSB;
        end else begin
            pos = r_pos;
        end
    end

    always_comb begin
        crc_next   = crc8_byte((pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : r_crc,
                               i_data.data_byte);
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_temp     = r_temp;
        n_humid    = r_humid;
        n_tgood    = r_tgood;
        o_job_push = 1'b0;
        o_job      = '{temp_raw: r_temp, humid_raw: r_humid,
                       ok: r_tgood && (r_crc == i_data.data_byte)};
        if (i_accept) begin
            unique case (pos)
                POS_T_MSB: begin
                    n_temp = {i_data.data_byte, 8'h00};
                    n_crc  = crc_next;
                    n_pos  = POS_T_LSB;
                end
                POS_T_LSB: begin
                    n_temp = {r_temp[15:8], i_data.data_byte};
                    n_crc  = crc_next;
                    n_pos  = POS_T_CRC;
                end
                POS_T_CRC: begin
                    n_tgood = (r_crc == i_data.data_byte);
                    n_crc   = CRC_INIT;
                    n_pos   = POS_H_MSB;
                end
                POS_H_MSB: begin
                    n_humid = {i_data.data_byte, 8'h00};
                    n_crc   = crc_next;
                    n_pos   = POS_H_LSB;
                end
                POS_H_LSB: begin
                    n_humid = {r_humid[15:8], i_data.data_byte};
                    n_crc   = crc_next;
                    n_pos   = POS_H_CRC;
                end
                default: begin
                    o_job_push = 1'b1;
                    n_crc      = CRC_INIT;
                    n_pos      = POS_T_MSB;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_T_MSB;
            r_crc   <= CRC_INIT;
            r_temp  <= '0;
            r_humid <= '0;
            r_tgood <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_temp  <= n_temp;
            r_humid <= n_humid;
            r_tgood <= n_tgood;
        end
    end

endmodule

// ===== rtl/hsfd_queue.sv =====
// ----------------------------------------------------------------------------
// hsfd_queue
// Short job queue between the frame parser and the conversion pipeline.
// ----------------------------------------------------------------------------
module hsfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hsfd_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output hsfd_pkg::t_job o_job
);
    import hsfd_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/hsfd_back.sv =====
// ----------------------------------------------------------------------------
// hsfd_back
// Two-stage conversion pipeline: scale multiply, then reciprocal divide by
// 65535 and offset, into the result register.
// ----------------------------------------------------------------------------
module hsfd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  hsfd_pkg::t_job i_job,
    output logic           o_job_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output hsfd_pkg::t_out o_result
);
    import hsfd_pkg::*;

    logic        r_v1, r_v2;
    logic [26:0] r_tprod;
    logic [22:0] r_hprod;
    logic        r_ok;
    t_out        r_res;
    logic        en;
    logic [27:0] tsum;
    logic [23:0] hsum;
    logic [10:0] tq;
    logic [6:0]  hq;

    assign en        = !r_v2 || i_pop;
    assign o_job_pop = en && i_job_valid;
    assign o_empty   = !r_v2;
    assign o_result  = r_res;

    // floor(x / 65535) as (x + (x >> 16) + 1) >> 16
    assign tsum = {1'b0, r_tprod} + 28'(r_tprod[26:16]) + 28'd1;
    assign hsum = {1'b0, r_hprod} + 24'(r_hprod[22:16]) + 24'd1;
    assign tq   = tsum[26:16];
    assign hq   = hsum[22:16];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tprod <= {11'd0, i_job.temp_raw} * {16'd0, T_SCALE};
            r_hprod <= {7'd0, i_job.humid_raw} * {16'd0, H_SCALE};
            r_ok    <= i_job.ok;
            if (r_ok) begin
                r_res.temp_tenths <= $signed({1'b0, tq} - T_OFFSET);
                r_res.rh_pct      <= hq;
                r_res.status      <= 1'b0;
            end else begin
                r_res.temp_tenths <= '0;
                r_res.rh_pct      <= '0;
                r_res.status      <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_job_valid;
            r_v2 <= r_v1;
        end
    end

endmodule

// ===== rtl/humidity_sensor_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_core
// Six-byte sensor reply decoder with CRC-8 checks and unit conversion.
// Throughput: one byte per cycle while full is low, set by the combinational
// CRC-8 step. Path: an accepted sixth byte's job passes the queue, then the
// multiply stage, then the result register, each of which can stall.
// Reset: synchronous, active low; clears position, CRC and all valid state.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  hsfd_pkg::t_in  i_data,
    output logic           empty,
    input  logic           pop,
    output hsfd_pkg::t_out o_result
);
    import hsfd_pkg::*;

    logic job_push, job_pop, job_valid, q_full;
    t_job job_in, job_out;

    assign full = q_full;

    hsfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !q_full),
        .i_data     (i_data),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    hsfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (q_full),
        .o_valid (job_valid),
        .o_job   (job_out)
    );

    hsfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

// ===== rtl/hsfd_checker.sv =====
// ----------------------------------------------------------------------------
// hsfd_checker
// Port-level checks on the result side of the frame decoder.
// ----------------------------------------------------------------------------
module hsfd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           empty,
    input logic           pop,
    input hsfd_pkg::t_out o_result
);
    import hsfd_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("stalled result transaction changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status |->
            o_result.temp_tenths == 12'sd0 && o_result.rh_pct == 7'd0)
        else $error("checksum error result carries nonzero values");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_result.status |->
            o_result.temp_tenths >= -12'sd450 && o_result.temp_tenths <= 12'sd1300
            && o_result.rh_pct <= 7'd100)
        else $error("converted values out of range");

endmodule

bind humidity_sensor_frame_decoder_core hsfd_checker u_hsfd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
